// ===== hw/rtl/box_blur_3x3_rgb_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Assertion wrappers shared by the box blur RTL. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BBR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box blur: property violated");
// The consequent must hold in the cycle after the antecedent.
`define BBR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box blur: property violated");
`else
`define BBR_ASSERT_IMP(name, ante, cons)
`define BBR_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== hw/rtl/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Types, register codes and constants shared by the box blur unit and its
// stream interfaces.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int BBR_MAX_WIDTH = 1024;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int ROW_W        = 13;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

	// Register index codes, taken from paddr[2].
	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	// Operation codes of an input beat.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Sum of nine 8-bit values and its divide by nine as a reciprocal multiply.
	localparam int SUM_W   = 12;
	localparam int RECIP_W = 13;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
	localparam int RECIP_SHIFT = 16;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} out_beat_t;

endpackage

// ===== hw/rtl/bbr_stream_if.sv =====
// ----------------------------------------------------------------------------
// Box blur stream interfaces
// Valid/ready channels for incoming pixel beats and outgoing result beats.
// ----------------------------------------------------------------------------
interface bbr_in_if;
	import bbr_pkg::*;

	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bbr_out_if;
	import bbr_pkg::*;

	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/box_blur_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB unit
// Streaming 3x3 mean filter for RGB pixels in raster order, with two line
// memories, a 3x3 window and an APB-style register port for the frame size.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_unit_defines.svh"

// The unit takes one beat per clock and sustains one result per clock while
// the sink is ready; the rate is set by the two line memories, each with one
// read and one write port, which every beat reads and writes exactly once. A
// result passes from the edge that accepts the beat that releases it through
// the memory read, the window update and the registered channel sums, then
// the divide by nine goes into the output register, and the result leaves at
// the next edge at which the sink is ready. Pixel k of a frame is released
// by input beat k + W + 1, where W is the frame width, so after the last pixel
// of a frame the host sends W + 1 flush beats (operation = 1) to drain it.
// A flush beat that arrives inside the frame counts as a black pixel, and any
// beat after the frame's last pixel only drains. Interior pixels become the
// per-channel floor of the nine-pixel sum divided by nine; pixels on the first
// or last row or column pass through unchanged, and frames narrower or shorter
// than three pixels pass through entirely. A width of zero acts as one, a width
// above MAX_WIDTH acts as MAX_WIDTH, and a height of zero acts as one. Writing
// either register restarts the frame; write registers only while idle. The
// line memories are not cleared after reset and need no clearing pass.
module box_blur_3x3_rgb_unit #(
	parameter int MAX_WIDTH = bbr_pkg::BBR_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bbr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [bbr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	bbr_in_if.sink                          pixel,
	bbr_out_if.source                       blurred
);
	import bbr_pkg::*;

	// Column index width, and width of a value that can hold MAX_WIDTH itself.
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IDX_WIDTH: width_q <= pwdata[WIDTH_REG_W-1:0];
				REG_IDX_HEIGHT: height_q <= pwdata[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_IDX_WIDTH: prdata = CFG_DATA_W'(width_q);
			REG_IDX_HEIGHT: prdata = CFG_DATA_W'(height_q);
			default: prdata = '0;
		endcase
	end

	// Effective frame size after clamping.
	logic [CMP_W-1:0]        w_ext;
	logic [WW-1:0]           w_eff;
	logic [WW-1:0]           w_m1;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic [ROW_W-1:0]        h_m1;

	always_comb begin
		w_ext = CMP_W'(width_q);
		if (w_ext == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(w_ext);
		end
		w_m1  = w_eff - WW'(1);
		h_eff = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;
		h_m1  = ROW_W'(h_eff) - ROW_W'(1);
	end

	// ------------------------------------------------------------------
	// Handshake: every stage moves when the one after it has room, so the
	// output register and the stages before it absorb a stalled sink.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic out_en, s3_en, s2_en, s1_en;
	logic in_fire, s1_leave;

	assign out_en   = !out_valid_q || blurred.ready;
	assign s3_en    = !valid_s3 || out_en;
	assign s2_en    = !valid_s2 || s3_en;
	assign s1_en    = !valid_s1 || s2_en;
	assign in_fire  = pixel.valid && s1_en;
	assign s1_leave = valid_s1 && s2_en;
	assign pixel.ready = s1_en;

	// ------------------------------------------------------------------
	// Position of the incoming beat and the output it releases
	// ------------------------------------------------------------------
	logic [XW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [XW-1:0]    x_in;
	logic [WW-1:0]    x_plus;
	logic             wrap;
	logic             emit_in;
	logic [ROW_W-1:0] oy;
	logic [WW-1:0]    ox;
	logic             border_in;
	logic             last_in;
	rgb_t             px_in;

	always_comb begin
		x_in   = (WW'(col_q) >= w_eff) ? '0 : col_q;
		x_plus = WW'(x_in) + WW'(1);
		wrap   = x_plus >= w_eff;
		// At column zero the released pixel closes the row before last.
		if (x_in == '0) begin
			emit_in = row_q >= ROW_W'(2);
			oy      = row_q - ROW_W'(2);
			ox      = w_m1;
		end else begin
			emit_in = row_q != '0;
			oy      = row_q - ROW_W'(1);
			ox      = WW'(x_in) - WW'(1);
		end
		border_in = (oy == '0) || (oy >= h_m1) || (ox == '0) || (ox >= w_m1);
		last_in   = (oy == h_m1) && (ox == w_m1);
		if (pixel.data.operation == OP_FLUSH) begin
			px_in = '0;
		end else begin
			px_in = '{r: pixel.data.red_in, g: pixel.data.green_in, b: pixel.data.blue_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (emit_in && last_in) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= XW'(x_plus);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line memories. Each beat reads both rows at its column and
	// writes them back shifted by one row when it leaves the stage.
	// ------------------------------------------------------------------
	rgb_t          upper_mem [MAX_WIDTH];
	rgb_t          middle_mem [MAX_WIDTH];
	rgb_t          up_rd_s1, mid_rd_s1;
	rgb_t          px_s1;
	logic [XW-1:0] x_s1;
	logic          emit_s1, border_s1, last_s1;
	logic          fwd_s1;
	rgb_t          fwd_up_s1, fwd_mid_s1;
	rgb_t          up_eff, mid_eff;

	// With a single-column frame, or when a new frame follows right behind
	// the beat that ended the last one (both sit at column zero), the next
	// beat reads the column that the beat ahead of it writes in the same
	// cycle; the write data is forwarded.
	assign up_eff  = fwd_s1 ? fwd_up_s1 : up_rd_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			upper_mem[x_s1] <= mid_eff;
		end
		if (in_fire) begin
			up_rd_s1 <= upper_mem[x_in];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			middle_mem[x_s1] <= px_s1;
		end
		if (in_fire) begin
			mid_rd_s1 <= middle_mem[x_in];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1      <= px_in;
			x_s1       <= x_in;
			emit_s1    <= emit_in;
			border_s1  <= border_in;
			last_s1    <= last_in;
			fwd_s1     <= valid_s1 && (x_s1 == x_in);
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= px_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: 3x3 window, rows top to bottom, columns left to right. It
	// shifts once for every beat that leaves stage 1.
	// ------------------------------------------------------------------
	rgb_t window_q [9];
	logic border_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
		end else if (s1_leave) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r*3]   <= window_q[r*3+1];
				window_q[r*3+1] <= window_q[r*3+2];
			end
			window_q[2] <= up_eff;
			window_q[5] <= mid_eff;
			window_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
	end

	function automatic logic [SUM_W-1:0] sum9(input logic [8:0][7:0] v);
		logic [SUM_W-1:0] a, b, c, d;
		a = SUM_W'(v[0]) + SUM_W'(v[1]);
		b = SUM_W'(v[2]) + SUM_W'(v[3]);
		c = SUM_W'(v[4]) + SUM_W'(v[5]);
		d = SUM_W'(v[6]) + SUM_W'(v[7]);
		return (a + b) + (c + d) + SUM_W'(v[8]);
	endfunction

	logic [8:0][7:0]  taps_r, taps_g, taps_b;
	logic [SUM_W-1:0] sum_r, sum_g, sum_b;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			taps_r[i] = window_q[i].r;
			taps_g[i] = window_q[i].g;
			taps_b[i] = window_q[i].b;
		end
		sum_r = sum9(taps_r);
		sum_g = sum9(taps_g);
		sum_b = sum9(taps_b);
	end

	// ------------------------------------------------------------------
	// Stage 3: registered sums; the divide by nine is a multiply by the
	// reciprocal, exact for every sum of nine 8-bit values.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] sum_r_s3, sum_g_s3, sum_b_s3;
	rgb_t             center_s3;
	logic             border_s3, last_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && s3_en) begin
			sum_r_s3  <= sum_r;
			sum_g_s3  <= sum_g;
			sum_b_s3  <= sum_b;
			center_s3 <= window_q[4];
			border_s3 <= border_s2;
			last_s3   <= last_s2;
		end
	end

	logic [PROD_W-1:0] prod_r, prod_g, prod_b;

	assign prod_r = PROD_W'(sum_r_s3) * PROD_W'(RECIP_NINE);
	assign prod_g = PROD_W'(sum_g_s3) * PROD_W'(RECIP_NINE);
	assign prod_b = PROD_W'(sum_b_s3) * PROD_W'(RECIP_NINE);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	out_beat_t out_data_q;

	always_ff @(posedge clk) begin
		if (valid_s3 && out_en) begin
			if (border_s3) begin
				out_data_q.red_out   <= center_s3.r;
				out_data_q.green_out <= center_s3.g;
				out_data_q.blue_out  <= center_s3.b;
			end else begin
				out_data_q.red_out   <= prod_r[RECIP_SHIFT+7:RECIP_SHIFT];
				out_data_q.green_out <= prod_g[RECIP_SHIFT+7:RECIP_SHIFT];
				out_data_q.blue_out  <= prod_b[RECIP_SHIFT+7:RECIP_SHIFT];
			end
			out_data_q.frame_last <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= pixel.valid;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1 && emit_s1;
			end
			if (s3_en) begin
				valid_s3 <= valid_s2;
			end
			if (out_en) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	assign blurred.valid = out_valid_q;
	assign blurred.data  = out_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BBR_ASSERT_IMP(a_fwd_same_column, in_fire && valid_s1 && (x_s1 == x_in),
		(x_in == '0) || (w_eff == WW'(1)))
	`BBR_ASSERT_NXT(a_frame_end_restart, in_fire && emit_in && last_in, (col_q == '0) && (row_q == '0))
	`BBR_ASSERT_IMP(a_col_in_range, 1'b1, WW'(col_q) < w_eff)
	`BBR_ASSERT_IMP(a_row_in_range, 1'b1, row_q <= ROW_W'(h_eff) + ROW_W'(1))

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Box blur 3x3 RGB unit testbench
// Drives raster-order pixel frames into the unit and checks every blurred beat
// against a cycle-free predictor of the 3x3 mean filter. Frame sizes change
// between frames over the APB-style port, and the handshakes on both streams
// are paced at random in three phases.
// ----------------------------------------------------------------------------
module tb_top;
	import bbr_pkg::*;

	// Predicts the blurred stream from accepted pixel beats and checks the
	// beats that leave the unit. It keeps its own copy of the frame size, the
	// two stored rows, the 3x3 window and the frame position counters.
	class blur_scoreboard;
		rgb_t                    upper_row [BBR_MAX_WIDTH];
		rgb_t                    middle_row [BBR_MAX_WIDTH];
		rgb_t                    win [9];
		int unsigned             col_pos;
		int unsigned             row_pos;
		int unsigned             sent_in_frame;
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		out_beat_t               awaited [$];
		int unsigned             failures;
		int unsigned             results_seen;

		function new();
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			width_reg    = WIDTH_RESET;
			height_reg   = HEIGHT_RESET;
			failures     = 0;
			results_seen = 0;
			restart();
		endfunction

		// A register write starts a new frame; the stored rows survive it.
		function void restart();
			foreach (win[i])
				win[i] = '0;
			col_pos       = 0;
			row_pos       = 0;
			sent_in_frame = 0;
		endfunction

		function int unsigned cols();
			int unsigned w;
			w = width_reg;
			if (w < 1)
				w = 1;
			if (w > BBR_MAX_WIDTH)
				w = BBR_MAX_WIDTH;
			return w;
		endfunction

		function int unsigned rows();
			return (height_reg < 1) ? 1 : height_reg;
		endfunction

		function void write_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
			if (idx == REG_IDX_WIDTH)
				width_reg = value[WIDTH_REG_W-1:0];
			else
				height_reg = value[HEIGHT_REG_W-1:0];
			restart();
		endfunction

		function void step_column(input int unsigned x, input int unsigned w);
			x++;
			if (x >= w) begin
				x = 0;
				row_pos++;
			end
			col_pos = x;
		endfunction

		// One accepted pixel beat: shift it through the stored rows and the
		// window, then work out which pixel (if any) it releases.
		function void note_input(input in_beat_t beat);
			rgb_t        px;
			rgb_t        up;
			rgb_t        mid;
			int unsigned w, h, x, oy, ox, sr, sg, sbl;
			bit          emit;
			out_beat_t   res;

			w = cols();
			h = rows();
			// A flush beat inside the frame is a black pixel.
			px = (beat.operation == OP_FLUSH) ? rgb_t'('0) :
				rgb_t'{beat.red_in, beat.green_in, beat.blue_in};
			x = (col_pos >= w) ? 0 : col_pos;
			up  = upper_row[x];
			mid = middle_row[x];
			upper_row[x]  = mid;
			middle_row[x] = px;

			for (int r = 0; r < 3; r++) begin
				win[r*3]     = win[r*3 + 1];
				win[r*3 + 1] = win[r*3 + 2];
			end
			win[2] = up;
			win[5] = mid;
			win[8] = px;

			// The window center lags the input by one row and one pixel; at the
			// start of a row it is still the last pixel of the row before.
			if (x == 0) begin
				emit = (row_pos >= 2);
				oy   = emit ? row_pos - 2 : 0;
				ox   = w - 1;
			end else begin
				emit = (row_pos >= 1);
				oy   = emit ? row_pos - 1 : 0;
				ox   = x - 1;
			end

			if (!emit) begin
				step_column(x, w);
				return;
			end

			if (oy == 0 || oy >= h - 1 || ox == 0 || ox >= w - 1) begin
				res.red_out   = win[4].r;
				res.green_out = win[4].g;
				res.blue_out  = win[4].b;
			end else begin
				sr  = 0;
				sg  = 0;
				sbl = 0;
				foreach (win[i]) begin
					sr  += win[i].r;
					sg  += win[i].g;
					sbl += win[i].b;
				end
				res.red_out   = 8'(sr / 9);
				res.green_out = 8'(sg / 9);
				res.blue_out  = 8'(sbl / 9);
			end

			if (sent_in_frame >= h * w - 1) begin
				res.frame_last = 1'b1;
				col_pos        = 0;
				row_pos        = 0;
				sent_in_frame  = 0;
			end else begin
				res.frame_last = 1'b0;
				sent_in_frame++;
				step_column(x, w);
			end
			awaited.push_back(res);
		endfunction

		function void check_output(input out_beat_t got);
			out_beat_t want;

			if (awaited.size() == 0) begin
				$error("blurred beat with no pixel pending: r=%0d g=%0d b=%0d last=%0d",
					got.red_out, got.green_out, got.blue_out, got.frame_last);
				failures++;
				return;
			end
			want = awaited.pop_front();
			results_seen++;
			if (got.red_out !== want.red_out) begin
				$error("red_out expected %0d, got %0d", want.red_out, got.red_out);
				failures++;
			end
			if (got.green_out !== want.green_out) begin
				$error("green_out expected %0d, got %0d", want.green_out, got.green_out);
				failures++;
			end
			if (got.blue_out !== want.blue_out) begin
				$error("blue_out expected %0d, got %0d", want.blue_out, got.blue_out);
				failures++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last expected %0d, got %0d", want.frame_last, got.frame_last);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	// After the last pending result arrives, this pause of quiet cycles leaves
	// the unit's pipeline empty.
	localparam int LATENCY_PAUSE = 8;
	localparam int DRAIN_GUARD   = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	bbr_in_if  pixel_if ();
	bbr_out_if blurred_if ();

	blur_scoreboard scoreboard = new();

	// Pacing of the two streams, in percent of cycles spent idle or stalled.
	int          sender_idle_pct    = 30;
	int          receiver_stall_pct = 82;
	int unsigned beats_sent         = 0;
	int unsigned frames_done        = 0;
	int unsigned reg_writes         = 0;
	int unsigned readback_errors    = 0;

	box_blur_3x3_rgb_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_if),
		.blurred (blurred_if)
	);

	always #6 clk = ~clk;

	// The receiver checks each beat that leaves the unit and then decides
	// whether to stall the next cycle.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && blurred_if.valid === 1'b1 && blurred_if.ready === 1'b1)
			scoreboard.check_output(blurred_if.data);
		blurred_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Channel values lean toward the extremes so that sums near the limits
	// and exact multiples of nine show up often.
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic in_beat_t random_beat(input logic op);
		in_beat_t beat;
		beat.operation = op;
		beat.red_in    = pick_channel();
		beat.green_in  = pick_channel();
		beat.blue_in   = pick_channel();
		return beat;
	endfunction

	// Offers one beat, idling first at the current rate, and returns at the
	// clock edge at which the unit accepts it. valid stays high afterwards so
	// that back-to-back beats need no extra assignment.
	task automatic send_beat(input in_beat_t beat);
		while ($urandom_range(99) < sender_idle_pct) begin
			pixel_if.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_if.valid <= 1'b1;
		pixel_if.data  <= beat;
		do
			@(posedge clk);
		while (pixel_if.ready !== 1'b1);
		scoreboard.note_input(beat);
		beats_sent++;
	endtask

	// Stops the pixel stream, waits for every pending result and then lets the
	// pipeline run empty. Register writes that follow streaming come only after this.
	task automatic drain_and_settle();
		int unsigned waited;
		waited = 0;
		pixel_if.valid <= 1'b0;
		while (scoreboard.pending() != 0 && waited < DRAIN_GUARD) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY_PAUSE) @(posedge clk);
	endtask

	// Reads a register back and compares it with the value last written.
	task automatic cfg_readback(input logic idx);
		logic [CFG_DATA_W-1:0] want;
		want = (idx == REG_IDX_WIDTH) ? CFG_DATA_W'(scoreboard.width_reg) :
			CFG_DATA_W'(scoreboard.height_reg);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== want) begin
			$error("%s readback expected %0d, got %0d",
				(idx == REG_IDX_WIDTH) ? "image_width" : "image_height", want, prdata);
			readback_errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge that ends the access cycle, and the frame restarts there.
	task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		scoreboard.write_register(idx, value);
		reg_writes++;
		cfg_readback(idx);
	endtask

	// Sends the pixels of a frame with a few black flush beats mixed in. A
	// drained frame is followed by width + 1 drain beats, mostly flushes and
	// sometimes pixel beats whose data must be ignored.
	task automatic send_frame(input int unsigned pixel_count, input bit drained);
		int unsigned w;
		logic        op;
		w = scoreboard.cols();
		for (int unsigned k = 0; k < pixel_count; k++) begin
			op = ($urandom_range(24) == 0) ? OP_FLUSH : OP_PIXEL;
			send_beat(random_beat(op));
		end
		if (drained) begin
			for (int unsigned k = 0; k <= w; k++) begin
				op = ($urandom_range(9) == 0) ? OP_PIXEL : OP_FLUSH;
				send_beat(random_beat(op));
			end
			frames_done++;
		end
	endtask

	// Picks a new small frame size. Widths and heights of zero are included on
	// purpose, and now and then a wider row. Sometimes only one register changes.
	task automatic resize(input bit both);
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		int                    pick;
		w = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
		h = $urandom_range(8);
		pick = both ? 0 : $urandom_range(2);
		if (pick != 2)
			cfg_write(REG_IDX_WIDTH, w);
		if (pick != 1)
			cfg_write(REG_IDX_HEIGHT, h);
	endtask

	// One pacing phase: well-formed frames of random small sizes, some cut
	// short by a register write, and then one frame at a larger size.
	task automatic run_phase(input int send_pct, input int stall_pct,
			input int unsigned item_goal, input logic [CFG_DATA_W-1:0] wide,
			input logic [CFG_DATA_W-1:0] tall);
		int unsigned start;
		int unsigned area;
		bit          first;
		sender_idle_pct    = send_pct;
		receiver_stall_pct = stall_pct;
		start = beats_sent;
		first = 1'b1;
		while (beats_sent - start < item_goal) begin
			// Either reconfigure while idle, or stream the next frame right
			// behind the last one.
			if (first || $urandom_range(1) == 1) begin
				drain_and_settle();
				resize(first);
				first = 1'b0;
			end
			area = scoreboard.cols() * scoreboard.rows();
			if ($urandom_range(9) == 0) begin
				// Broken frame: stop partway, settle and restart with a write.
				send_frame($urandom_range(area - 1, 0), 1'b0);
				drain_and_settle();
				resize(1'b0);
			end else begin
				send_frame(area, 1'b1);
			end
		end
		drain_and_settle();
		cfg_write(REG_IDX_WIDTH, wide);
		cfg_write(REG_IDX_HEIGHT, tall);
		send_frame(scoreboard.cols() * scoreboard.rows(), 1'b1);
	endtask

	initial begin
		logic [23:0] demo_px [12];
		in_beat_t    beat;

		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		pixel_if.valid   = 1'b0;
		pixel_if.data    = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// The registers must come out of reset at their documented values.
		cfg_readback(REG_IDX_WIDTH);
		cfg_readback(REG_IDX_HEIGHT);

		// A 4x3 frame has two interior pixels. The rows mix full white, black,
		// single channels and values just off the extremes; the beat in the
		// middle row is a flush, which acts as a black pixel. Its data and that
		// of the pixel beat among the drain beats must not reach any output.
		cfg_write(REG_IDX_WIDTH, 4);
		cfg_write(REG_IDX_HEIGHT, 3);
		demo_px = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00,
			24'hFFFFFF, 24'hFEFDFC, 24'hFFFFFF, 24'h090807,
			24'h010203, 24'hFFFFFF, 24'h80807F, 24'h000000};
		for (int k = 0; k < 12; k++) begin
			beat.operation = (k == 6) ? OP_FLUSH : OP_PIXEL;
			{beat.red_in, beat.green_in, beat.blue_in} = demo_px[k];
			send_beat(beat);
		end
		for (int k = 0; k < 5; k++) begin
			beat.operation = (k == 2) ? OP_PIXEL : OP_FLUSH;
			{beat.red_in, beat.green_in, beat.blue_in} = 24'hFFFFFF;
			send_beat(beat);
		end
		frames_done++;

		// Zero width and height act as a one-pixel frame.
		drain_and_settle();
		cfg_write(REG_IDX_WIDTH, 0);
		cfg_write(REG_IDX_HEIGHT, 0);
		send_frame(1, 1'b1);

		// Stop a 3x3 frame after two rows' worth of pixels; the next register
		// write in the first phase restarts it from pixel (0,0).
		drain_and_settle();
		cfg_write(REG_IDX_WIDTH, 3);
		cfg_write(REG_IDX_HEIGHT, 3);
		send_frame(6, 1'b0);

		// Sender idle 30 / receiver stalled 82, then the reverse, then no
		// idling at all. Each phase ends with one frame at a larger size:
		// wide rows, a tall single-column frame, and a wide two-row frame.
		run_phase(30, 82, 360, 64, 3);
		run_phase(82, 30, 360, 1, 256);
		run_phase(0, 0, 360, 48, 2);

		drain_and_settle();
		if (scoreboard.pending() != 0) begin
			$error("%0d blurred beats never arrived", scoreboard.pending());
			scoreboard.failures++;
		end

		$display("Covered %0d pixel beats in %0d drained frames with %0d register writes,",
			beats_sent, frames_done, reg_writes);
		$display("and checked %0d blurred beats under three stream pacing phases.",
			scoreboard.results_seen);
		if (scoreboard.failures == 0 && readback_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of all phases together.
	initial begin
		#12000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_stream_if.sv
hw/rtl/box_blur_3x3_rgb_unit.sv
tb/sv/tb_top.sv
